### sv/dbm_pkg.sv
// ---------------------------------------------------------------------------
// dbm_pkg: shared types and constants of the decimal bignum multiplier
// Digit width, column sum width and the item that the front passes to the back.
// ---------------------------------------------------------------------------
package dbm_pkg;

	localparam int MAX_DIGITS_DEF = 32;
	localparam int DIGIT_W        = 4;
	localparam int SUM_W          = 12;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
	// 2^16 / 10 rounded up; exact quotient for sums below 4096
	localparam logic [12:0] RECIP_TEN = 13'd6554;

	typedef struct packed {
		logic               operand;
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} item_t;

endpackage

### sv/dbm_front.sv
// ---------------------------------------------------------------------------
// dbm_front: input side of the decimal bignum multiplier
// Accepts digit items, saturates the digit and queues them for the back end.
// ---------------------------------------------------------------------------
module dbm_front import dbm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [3:0] digit, [7:4] zero
	input  logic       s_tuser,   // [0] operand
	input  logic       s_tlast,
	output logic       q_valid,
	output item_t      q_item,
	input  logic       q_pop
);

	item_t                 queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QPTR_W:0]       count_q;
	logic                  push;
	logic                  pop;
	item_t                 in_item;

	assign s_tready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = queue_q[rd_ptr_q];

	always_comb begin
		in_item.operand = s_tuser;
		in_item.last    = s_tlast;
		// clamp anything above nine
		in_item.digit   = (s_tdata[3:0] > DIGIT_MAX) ? DIGIT_MAX : s_tdata[3:0];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/dbm_back.sv
// ---------------------------------------------------------------------------
// dbm_back: operand store and schoolbook multiply engine
// Stores digits, sums digit products column by column, emits the product.
// ---------------------------------------------------------------------------
module dbm_back import dbm_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  item_t      q_item,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [3:0] product_digit, [7:4] zero
	output logic       m_tuser,   // [0] overflow
	output logic       m_tlast
);

	localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int LW = $clog2(MAX_DIGITS + 1);
	localparam int KW = $clog2(2 * MAX_DIGITS + 1);
	localparam int RW = $clog2(2 * MAX_DIGITS);
	localparam int RES_DEPTH = 2 * MAX_DIGITS;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_COMP  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [DIGIT_W-1:0] mem_a [MAX_DIGITS];
	logic [DIGIT_W-1:0] mem_b [MAX_DIGITS];
	logic [DIGIT_W-1:0] res_mem [RES_DEPTH];

	logic [2:0]         state_q;
	logic [LW-1:0]      len_a_q, len_b_q;
	logic               closed_a_q, closed_b_q, ovf_q;
	logic [KW-1:0]      k_q, wa_q, out_k_q, len0;
	logic [KW-1:0]      hi_k, lo_next, k_next;
	logic               col_end, all_end, issue;
	logic [AW-1:0]      a_addr, b_addr;

	logic               valid_s1, col_end_s1, last_s1;
	logic [KW-1:0]      k_s1;
	logic [DIGIT_W-1:0] a_rd_s1, b_rd_s1;
	logic               valid_s2, col_end_s2, last_s2;
	logic [KW-1:0]      k_s2;
	logic [7:0]         prod_s2;

	logic [SUM_W-1:0]   acc_q, carry_q, sum, col_val, quo, rem;
	logic [24:0]        recip_prod;
	logic [DIGIT_W-1:0] res_rd_q;
	logic               res_we;
	logic [RW-1:0]      res_waddr;
	logic [DIGIT_W-1:0] res_wdata;

	logic               take;
	logic               store_ok;

	// ---- load side ----
	assign q_pop    = (state_q == S_IDLE) && !(closed_a_q && closed_b_q);
	assign take     = q_pop && q_valid;
	assign store_ok = q_item.operand ? (!closed_b_q && (len_b_q < LW'(MAX_DIGITS)))
	                                 : (!closed_a_q && (len_a_q < LW'(MAX_DIGITS)));

	always_ff @(posedge clk) begin
		if (take && store_ok && !q_item.operand) begin
			mem_a[len_a_q[AW-1:0]] <= q_item.digit;
		end
		if (take && store_ok && q_item.operand) begin
			mem_b[len_b_q[AW-1:0]] <= q_item.digit;
		end
		a_rd_s1 <= mem_a[a_addr];
		b_rd_s1 <= mem_b[b_addr];
	end

	// ---- column walk ----
	assign len0    = KW'(len_a_q) + KW'(len_b_q) - 1'b1;
	assign hi_k    = (k_q < KW'(len_a_q)) ? k_q : (KW'(len_a_q) - 1'b1);
	assign k_next  = k_q + 1'b1;
	assign lo_next = (k_next >= KW'(len_b_q)) ? (k_next - KW'(len_b_q) + 1'b1) : '0;
	assign col_end = (wa_q == hi_k);
	assign all_end = col_end && (k_q == len0 - 1'b1);
	assign issue   = (state_q == S_COMP);
	assign a_addr  = AW'(KW'(len_a_q) - 1'b1 - wa_q);
	assign b_addr  = AW'(KW'(len_b_q) - 1'b1 - (k_q - wa_q));

	// ---- accumulate and split a column into digit and carry ----
	assign sum        = acc_q + SUM_W'(prod_s2);
	assign col_val    = sum + carry_q;
	assign recip_prod = 25'(col_val) * 25'(RECIP_TEN);
	assign quo        = SUM_W'(recip_prod[24:16]);
	assign rem        = col_val - ((quo << 3) + (quo << 1));

	always_comb begin
		res_we    = 1'b0;
		res_waddr = RW'(k_s2);
		res_wdata = rem[DIGIT_W-1:0];
		if (valid_s2 && col_end_s2) begin
			res_we = 1'b1;
		end else if (state_q == S_FIN && carry_q != '0) begin
			res_we    = 1'b1;
			res_waddr = RW'(len0);
			res_wdata = carry_q[DIGIT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			res_mem[res_waddr] <= res_wdata;
		end
		res_rd_q <= res_mem[RW'(out_k_q - 1'b1)];
		k_s1       <= k_q;
		k_s2       <= k_s1;
		prod_s2    <= 8'(a_rd_s1) * 8'(b_rd_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			len_a_q    <= '0;
			len_b_q    <= '0;
			closed_a_q <= 1'b0;
			closed_b_q <= 1'b0;
			ovf_q      <= 1'b0;
			k_q        <= '0;
			wa_q       <= '0;
			out_k_q    <= '0;
			valid_s1   <= 1'b0;
			col_end_s1 <= 1'b0;
			last_s1    <= 1'b0;
			valid_s2   <= 1'b0;
			col_end_s2 <= 1'b0;
			last_s2    <= 1'b0;
			acc_q      <= '0;
			carry_q    <= '0;
		end else begin
			valid_s1   <= issue;
			col_end_s1 <= issue && col_end;
			last_s1    <= issue && all_end;
			valid_s2   <= valid_s1;
			col_end_s2 <= col_end_s1;
			last_s2    <= last_s1;

			if (valid_s2) begin
				if (col_end_s2) begin
					acc_q   <= '0;
					carry_q <= quo;
				end else begin
					acc_q <= sum;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (closed_a_q && closed_b_q) begin
						state_q <= S_COMP;
						k_q     <= '0;
						wa_q    <= '0;
						acc_q   <= '0;
						carry_q <= '0;
					end else if (take) begin
						if (!q_item.operand && !closed_a_q) begin
							if (store_ok) begin
								len_a_q <= len_a_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
							if (q_item.last) begin
								closed_a_q <= 1'b1;
							end
						end
						if (q_item.operand && !closed_b_q) begin
							if (store_ok) begin
								len_b_q <= len_b_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
							if (q_item.last) begin
								closed_b_q <= 1'b1;
							end
						end
					end
				end
				S_COMP: begin
					if (col_end) begin
						k_q  <= k_next;
						wa_q <= lo_next;
					end else begin
						wa_q <= wa_q + 1'b1;
					end
					if (all_end) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (valid_s2 && last_s2) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// grow by one digit only on a nonzero top carry
					out_k_q <= (carry_q != '0) ? (len0 + 1'b1) : len0;
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) begin
						if (out_k_q == KW'(1)) begin
							state_q    <= S_IDLE;
							len_a_q    <= '0;
							len_b_q    <= '0;
							closed_a_q <= 1'b0;
							closed_b_q <= 1'b0;
							ovf_q      <= 1'b0;
						end else begin
							out_k_q <= out_k_q - 1'b1;
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = {4'd0, res_rd_q};
	assign m_tuser  = ovf_q;
	assign m_tlast  = (out_k_q == KW'(1));

endmodule

### sv/decimal_bignum_multiplier_unit.sv
// ---------------------------------------------------------------------------
// decimal_bignum_multiplier_unit: schoolbook decimal long multiplier
// Loads two decimal operands digit by digit and streams out their product.
// ---------------------------------------------------------------------------
// channel | dir | tdata              | tuser        | tlast
// s_*     | in  | [3:0] digit        | [0] operand  | last digit of operand
// m_*     | out | [3:0] product_digit| [0] overflow | least significant digit
//
// A digit item is written to its operand store as it leaves the input queue,
// unless that operand is closed or full. A product is formed in the single
// multiply-accumulate unit, then each digit is read (S_READ) and offered (S_OUT).
// While a product is formed or emitted the queue takes up to QUEUE_DEPTH items.
// Reset clears lengths, flags and the queue; digit stores need no clearing.
// ---------------------------------------------------------------------------
module decimal_bignum_multiplier_unit import dbm_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [3:0] digit, [7:4] zero
	input  logic       s_tuser,   // [0] operand
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [3:0] product_digit, [7:4] zero
	output logic       m_tuser,   // [0] overflow
	output logic       m_tlast
);

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	dbm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	dbm_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the decimal bignum multiplier
// Streams operand digits from directed rows, maximum and overlong operands, random
// operand pairs and noise digits, predicts every product digit and compares each output item in order.
// ---------------------------------------------------------------------------
module tb;
	import dbm_pkg::*;

	localparam int MAXD       = 32;
	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 290;

	typedef struct packed {
		logic [3:0] digit;
		logic       tail;
		logic       ovf;
	} prod_digit_t;

	typedef struct {
		logic       operand;
		logic [3:0] digit;
		logic       last;
		int         want;   // typed-in product digit of the row, -1 if none
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;    // [3:0] digit, [7:4] zero
	logic       s_tuser;    // [0] operand
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;    // [3:0] product_digit, [7:4] zero
	logic       m_tuser;    // [0] overflow
	logic       m_tlast;

	decimal_bignum_multiplier_unit dut (.*);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [3:0] a_digits [MAXD];
	logic [3:0] b_digits [MAXD];
	int         a_len, b_len;
	bit         a_closed, b_closed, ovf_seen;

	prod_digit_t product_queue[$];
	int          typed_queue[$];
	int          errors = 0;
	int          products_seen = 0;
	int          digits_checked = 0;
	int          idle_free = 0;   // nonzero: no idling on either side
	int          quiet_cycles = 0;

	function automatic void predict_digit(logic op, logic [3:0] d_in, logic end_flag,
			int want);
		logic [3:0] d;
		int cols [2*MAXD+1];
		int n, carry, v;
		d = (d_in > 4'd9) ? 4'd9 : d_in;
		if (op == 1'b0) begin
			if (!a_closed) begin
				if (a_len < MAXD) begin
					a_digits[a_len] = d;
					a_len++;
				end else ovf_seen = 1;
				if (end_flag) a_closed = 1;
			end
		end else if (!b_closed) begin
			if (b_len < MAXD) begin
				b_digits[b_len] = d;
				b_len++;
			end else ovf_seen = 1;
			if (end_flag) b_closed = 1;
		end
		if (!(a_closed && b_closed)) return;
		foreach (cols[k]) cols[k] = 0;
		for (int i = 0; i < a_len; i++)
			for (int j = 0; j < b_len; j++)
				cols[(a_len-1-i) + (b_len-1-j)] += a_digits[i] * b_digits[j];
		n = a_len + b_len - 1;
		carry = 0;
		for (int k = 0; k < n; k++) begin
			v = cols[k] + carry;
			cols[k] = v % 10;
			carry = v / 10;
		end
		while (carry != 0 && n < 2*MAXD) begin
			cols[n] = carry % 10;
			carry /= 10;
			n++;
		end
		for (int k = n; k > 0; k--) begin
			product_queue.push_back('{cols[k-1][3:0], k == 1, ovf_seen});
			// a typed-in value applies to the most significant digit only
			typed_queue.push_back(k == n ? want : -1);
		end
		a_len = 0;
		b_len = 0;
		a_closed = 0;
		b_closed = 0;
		ovf_seen = 0;
	endfunction

	// drive one item and wait for it to be taken; drop valid only while idling
	task automatic send_digit(logic op, logic [3:0] d, logic end_flag, int want);
		while (idle_free == 0 && $urandom_range(99) < 35) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, d};
		s_tuser  <= op;
		s_tlast  <= end_flag;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_digit(op, d, end_flag, want);
	endtask

	task automatic send_operand(logic op, int n, bit zero_fill);
		for (int i = 0; i < n; i++)
			send_digit(op, zero_fill ? 4'd0 : 4'($urandom_range(9)), i == n-1, -1);
	endtask

	// output side: random stall, compare each taken item
	always @(posedge clk) begin
		prod_digit_t exp_d;
		int want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				digits_checked++;
				if (product_queue.size() == 0) begin
					$error("unexpected product digit %0d", m_tdata[3:0]);
					errors++;
				end else begin
					exp_d = product_queue.pop_front();
					want = typed_queue.pop_front();
					if (m_tlast) products_seen++;
					if (m_tdata[3:0] !== exp_d.digit) begin
						$error("product_digit expected %0d actual %0d", exp_d.digit,
							m_tdata[3:0]);
						errors++;
					end
					if (want >= 0 && m_tdata[3:0] !== 4'(want)) begin
						$error("product_digit expected %0d actual %0d", want, m_tdata[3:0]);
						errors++;
					end
					if (m_tdata[7:4] !== 4'd0) begin
						$error("tdata pad expected 0 actual %0h", m_tdata[7:4]);
						errors++;
					end
					if (m_tlast !== exp_d.tail) begin
						$error("final_digit expected %0d actual %0d", exp_d.tail, m_tlast);
						errors++;
					end
					if (m_tuser !== exp_d.ovf) begin
						$error("overflow expected %0d actual %0d", exp_d.ovf, m_tuser);
						errors++;
					end
				end
			end
			m_tready <= (idle_free != 0) || ($urandom_range(99) >= 35);
		end
	end

	// watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	stim_row_t directed_rows[] = '{
		// 9 x 9 = 81
		'{1'b0, 4'd9, 1'b1, -1}, '{1'b1, 4'd9, 1'b1, 8},
		// 0 x 0 = 0
		'{1'b0, 4'd0, 1'b1, -1}, '{1'b1, 4'd0, 1'b1, 0},
		// digit above nine saturates: 15 x 12 -> 9 x 9 = 81
		'{1'b1, 4'd15, 1'b1, -1}, '{1'b0, 4'd12, 1'b1, 8},
		// digit to a closed operand is dropped: 3 then 7 ignored, x 45
		'{1'b0, 4'd3, 1'b1, -1}, '{1'b0, 4'd7, 1'b1, -1},
		'{1'b1, 4'd4, 1'b0, -1}, '{1'b1, 4'd5, 1'b1, 1},
		// 00 x 5: leading zeros kept, product 00
		'{1'b0, 4'd0, 1'b0, -1}, '{1'b0, 4'd0, 1'b1, -1},
		'{1'b1, 4'd5, 1'b1, 0},
		// interleaved operands: 12 x 34 = 408
		'{1'b0, 4'd1, 1'b0, -1}, '{1'b1, 4'd3, 1'b0, -1},
		'{1'b0, 4'd2, 1'b1, -1}, '{1'b1, 4'd4, 1'b1, 4},
		// 99 x 99 = 9801
		'{1'b0, 4'd9, 1'b0, -1}, '{1'b0, 4'd9, 1'b1, -1},
		'{1'b1, 4'd9, 1'b0, -1}, '{1'b1, 4'd9, 1'b1, 9}
	};

	initial begin
		int sent;
		int la, lb, kind;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		a_len = 0;
		b_len = 0;
		a_closed = 0;
		b_closed = 0;
		ovf_seen = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_digit(directed_rows[r].operand, directed_rows[r].digit,
				directed_rows[r].last, directed_rows[r].want);

		// longest operands of random digits, then both too long with overflow
		send_operand(1'b0, MAXD, 0);
		send_operand(1'b1, MAXD, 0);
		send_operand(1'b0, MAXD + 3, 0);
		send_operand(1'b1, MAXD + 1, 0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= 150 && sent < 230) idle_free = 1;
			else idle_free = 0;
			kind = $urandom_range(19);
			if (kind == 0) begin
				// stray noise digit, any 4-bit value
				send_digit(1'($urandom_range(1)), 4'($urandom), 1'($urandom_range(1)), -1);
				sent++;
			end else begin
				la = (kind == 1) ? MAXD + $urandom_range(2) :
					(kind < 4) ? $urandom_range(MAXD) + 0 : $urandom_range(1, 6);
				lb = (kind == 2) ? MAXD : $urandom_range(1, 6);
				if (la == 0) la = 1;
				if ($urandom_range(1)) begin
					send_operand(1'b0, la, kind == 3);
					send_operand(1'b1, lb, 0);
				end else begin
					send_operand(1'b1, lb, 0);
					send_operand(1'b0, la, kind == 3);
				end
				sent += la + lb;
			end
		end
		idle_free = 0;
		// close any operand left open by noise
		if (a_closed || b_closed || a_len != 0 || b_len != 0) begin
			if (!a_closed) send_digit(1'b0, 4'd1, 1'b1, -1);
			if (!b_closed) send_digit(1'b1, 4'd1, 1'b1, -1);
		end
		s_tvalid <= 1'b0;

		while (product_queue.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d products, %0d product digits checked", products_seen,
			digits_checked);
		if (errors == 0 && product_queue.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
